// ----- hw/rtl/absolute_encoder_turn_tracker_core_defines.svh -----
// Assertion helpers for the turn tracker RTL.
`ifndef ABSOLUTE_ENCODER_TURN_TRACKER_CORE_DEFINES_SVH
`define ABSOLUTE_ENCODER_TURN_TRACKER_CORE_DEFINES_SVH

// Check a property on the rising clock edge, ignoring cycles in reset.
`define AETT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define AETT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/aett_pkg.sv -----
package aett_pkg;

  localparam int unsigned POS_W       = 24;
  localparam int unsigned CV_W        = 25;
  localparam int unsigned CPR_W       = 16;
  localparam int unsigned ANG_W       = 17;
  localparam int unsigned DEBOUNCE_MS = 50;
  localparam int unsigned MS_W        = $clog2(DEBOUNCE_MS + 1);
  localparam int unsigned FULL_TURN   = 36000;
  localparam int unsigned SCALE_W     = 16;
  localparam int unsigned SHAFT_W     = 40;
  localparam int unsigned DVD_W       = SHAFT_W + SCALE_W;
  localparam int unsigned CNT_W       = $clog2(DVD_W + 1);
  localparam int unsigned CFG_W       = 17;
  localparam int unsigned CFG_IDX_W   = 3;

  typedef enum logic [2:0] {
    OP_READING     = 3'd0,
    OP_TICK        = 3'd1,
    OP_SET_TURN    = 3'd2,
    OP_SET_COUNTS  = 3'd3,
    OP_CLEAR_DIRTY = 3'd4,
    OP_ZERO        = 3'd5,
    OP_LOAD_TURN   = 3'd6
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPR    = 3'd0,
    CFG_INVERT = 3'd1,
    CFG_AXMAX  = 3'd2,
    CFG_NUM    = 3'd3,
    CFG_DEN    = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV_MOD  = 2'd0,
    DIV_ANG  = 2'd1,
    DIV_SCL  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     exec;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_step;
    logic     apply;
    logic     mul;
    logic     fin;
  } cmd_t;

  typedef struct packed {
    logic need_mod;
    logic cpr_zero;
    logic div_done;
  } stat_t;

endpackage

// ----- hw/rtl/aett_in_if.sv -----
interface aett_in_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   operation;
  logic [aett_pkg::POS_W-1:0]   position;
  logic                         reading_valid;
  logic                         turn_value;
  logic signed [aett_pkg::CV_W-1:0] counts_value;

  modport source (output valid, operation, position, reading_valid, turn_value,
                  counts_value, input ready);
  modport sink   (input valid, operation, position, reading_valid, turn_value,
                  counts_value, output ready);
endinterface

// ----- hw/rtl/aett_out_if.sv -----
interface aett_out_if;
  logic                         valid;
  logic                         ready;
  logic [aett_pkg::POS_W-1:0]   position_counts;
  logic [aett_pkg::POS_W-1:0]   extended_counts;
  logic [aett_pkg::ANG_W-1:0]   angle_deg01;
  logic                         angle_valid;
  logic                         turn;
  logic                         persist_request;

  modport source (output valid, position_counts, extended_counts, angle_deg01,
                  angle_valid, turn, persist_request, input ready);
  modport sink   (input valid, position_counts, extended_counts, angle_deg01,
                  angle_valid, turn, persist_request, output ready);
endinterface

// ----- hw/rtl/aett_ctrl.sv -----
module aett_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  aett_pkg::stat_t stat,
  output aett_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MOD, S_APPLY, S_RAW, S_DIV1, S_MUL, S_D2LD, S_DIV2, S_FIN
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.div_sel = aett_pkg::DIV_MOD;
    unique case (state_r)
      S_IDLE:   cmd.load = in_valid && in_ready;
      S_DECODE: begin
        if (stat.need_mod) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.exec = 1'b1;
        end
      end
      S_MOD:    cmd.div_step = !stat.div_done;
      S_APPLY:  cmd.apply = 1'b1;
      S_RAW: begin
        cmd.div_start = !stat.cpr_zero;
        cmd.div_sel   = aett_pkg::DIV_ANG;
      end
      S_DIV1:   cmd.div_step = !stat.div_done;
      S_MUL:    cmd.mul = 1'b1;
      S_D2LD: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = aett_pkg::DIV_SCL;
      end
      S_DIV2:   cmd.div_step = !stat.div_done;
      S_FIN:    cmd.fin = 1'b1;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE:   if (in_valid && in_ready) state_r <= S_DECODE;
        S_DECODE: state_r <= stat.need_mod ? S_MOD : S_RAW;
        S_MOD:    if (stat.div_done) state_r <= S_APPLY;
        S_APPLY:  state_r <= S_RAW;
        S_RAW:    state_r <= stat.cpr_zero ? S_FIN : S_DIV1;
        S_DIV1:   if (stat.div_done) state_r <= S_MUL;
        S_MUL:    state_r <= S_D2LD;
        S_D2LD:   state_r <= S_DIV2;
        S_DIV2:   if (stat.div_done) state_r <= S_FIN;
        S_FIN: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default:  state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/aett_dp.sv -----
module aett_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [aett_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aett_pkg::CFG_W-1:0]      cfg_data,
  input  logic [2:0]                      in_operation,
  input  logic [aett_pkg::POS_W-1:0]      in_position,
  input  logic                            in_reading_valid,
  input  logic                            in_turn_value,
  input  logic signed [aett_pkg::CV_W-1:0] in_counts_value,
  input  aett_pkg::cmd_t                  cmd,
  output aett_pkg::stat_t                 stat,
  output logic [aett_pkg::POS_W-1:0]      out_position_counts,
  output logic [aett_pkg::POS_W-1:0]      out_extended_counts,
  output logic [aett_pkg::ANG_W-1:0]      out_angle_deg01,
  output logic                            out_angle_valid,
  output logic                            out_turn,
  output logic                            out_persist_request
);

  // configuration
  logic [aett_pkg::CPR_W-1:0]   cpr_r, num_r, den_r;
  logic                         inv_r;
  logic [aett_pkg::ANG_W-1:0]   axmax_r;

  // captured item
  logic [2:0]                       op_r;
  logic [aett_pkg::POS_W-1:0]       pos_r;
  logic                             rv_r, tv_r;
  logic signed [aett_pkg::CV_W-1:0] cv_r;

  // tracker state
  logic [aett_pkg::POS_W-1:0] cur_r;
  logic                       have_prev_r, turn_r, seen_r, dirty_r, chk_r;
  logic [aett_pkg::MS_W-1:0]  ms_r;

  // serial divider
  logic [aett_pkg::DVD_W-1:0] quo_r;
  logic [aett_pkg::CPR_W-1:0] rem_r, dvs_r;
  logic [aett_pkg::CNT_W-1:0] cnt_r;
  logic [aett_pkg::DVD_W-1:0] prod_r;

  logic [aett_pkg::CPR_W:0]   trial;
  logic                       ge;
  logic [aett_pkg::CPR_W-1:0] num_eff, den_eff;
  logic [aett_pkg::SHAFT_W-1:0] shaft_prod;

  // reading apply
  logic [aett_pkg::POS_W-1:0] m;
  logic [aett_pkg::CPR_W-1:0] half;
  logic                       nt;

  // finish
  logic [aett_pkg::ANG_W-1:0] amax, overlap;
  logic                       clr, turn_f, dirty_f, avalid;
  logic [aett_pkg::MS_W-1:0]  ms_f;
  logic [aett_pkg::ANG_W:0]   ang_sum;
  logic [aett_pkg::ANG_W-1:0] ang;

  logic [aett_pkg::POS_W-1:0] sc_clamp;

  assign num_eff = (num_r == '0) ? aett_pkg::CPR_W'(1) : num_r;
  assign den_eff = (den_r == '0) ? aett_pkg::CPR_W'(1) : den_r;
  assign shaft_prod = aett_pkg::SHAFT_W'(cur_r) *
                      aett_pkg::SHAFT_W'(aett_pkg::FULL_TURN);

  assign trial = {rem_r, quo_r[aett_pkg::DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  assign stat.need_mod = (op_r == aett_pkg::OP_READING) && rv_r && (cpr_r != '0);
  assign stat.cpr_zero = (cpr_r == '0);
  assign stat.div_done = (cnt_r == '0);

  always_comb begin
    m = aett_pkg::POS_W'(rem_r);
    if (inv_r && rem_r != '0) m = aett_pkg::POS_W'(cpr_r - rem_r);
    half = cpr_r >> 1;
    nt = turn_r;
    if (cur_r > m && (cur_r - m) > aett_pkg::POS_W'(half)) nt = 1'b1;
    else if (m > cur_r && (m - cur_r) > aett_pkg::POS_W'(half)) nt = 1'b0;
  end

  always_comb begin
    if (cv_r < 0) begin
      sc_clamp = '0;
    end else if (cpr_r != '0 && cv_r[aett_pkg::POS_W-1:0] >= aett_pkg::POS_W'(cpr_r)) begin
      sc_clamp = aett_pkg::POS_W'(cpr_r - aett_pkg::CPR_W'(1));
    end else begin
      sc_clamp = cv_r[aett_pkg::POS_W-1:0];
    end
  end

  always_comb begin
    amax    = (axmax_r == '0) ? aett_pkg::ANG_W'(aett_pkg::FULL_TURN) : axmax_r;
    overlap = (amax > aett_pkg::ANG_W'(aett_pkg::FULL_TURN)) ?
              amax - aett_pkg::ANG_W'(aett_pkg::FULL_TURN) : '0;
    clr     = chk_r && turn_r && (quo_r > aett_pkg::DVD_W'(overlap));
    turn_f  = turn_r && !clr;
    dirty_f = dirty_r || clr;
    ms_f    = clr ? '0 : ms_r;
    avalid  = seen_r && (cpr_r != '0);
    ang_sum = aett_pkg::ANG_W'(quo_r) +
              (turn_f ? (aett_pkg::ANG_W+1)'(aett_pkg::FULL_TURN) : '0);
    if (!avalid) ang = '0;
    else if (quo_r > aett_pkg::DVD_W'(amax)) ang = amax;
    else if (ang_sum > (aett_pkg::ANG_W+1)'(amax)) ang = amax;
    else ang = ang_sum[aett_pkg::ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r       <= aett_pkg::CPR_W'(4096);
      inv_r       <= 1'b0;
      axmax_r     <= '0;
      num_r       <= aett_pkg::CPR_W'(1);
      den_r       <= aett_pkg::CPR_W'(1);
      cur_r       <= '0;
      have_prev_r <= 1'b0;
      turn_r      <= 1'b0;
      seen_r      <= 1'b0;
      dirty_r     <= 1'b0;
      ms_r        <= '0;
      chk_r       <= 1'b0;
      cnt_r       <= '0;
      op_r        <= 3'(aett_pkg::OP_TICK);
      rv_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (aett_pkg::cfg_idx_t'(cfg_index))
          aett_pkg::CFG_CPR:    cpr_r   <= cfg_data[aett_pkg::CPR_W-1:0];
          aett_pkg::CFG_INVERT: inv_r   <= cfg_data[0];
          aett_pkg::CFG_AXMAX:  axmax_r <= cfg_data[aett_pkg::ANG_W-1:0];
          aett_pkg::CFG_NUM:    num_r   <= cfg_data[aett_pkg::CPR_W-1:0];
          aett_pkg::CFG_DEN:    den_r   <= cfg_data[aett_pkg::CPR_W-1:0];
          default: ;
        endcase
      end

      if (cmd.load) begin
        op_r  <= in_operation;
        pos_r <= in_position;
        rv_r  <= in_reading_valid;
        tv_r  <= in_turn_value;
        cv_r  <= in_counts_value;
        chk_r <= 1'b0;
      end

      if (cmd.exec) begin
        case (aett_pkg::op_t'(op_r))
          aett_pkg::OP_READING: begin
            if (rv_r) begin
              seen_r      <= 1'b1;
              cur_r       <= pos_r;
              have_prev_r <= 1'b1;
            end
          end
          aett_pkg::OP_TICK: begin
            if (ms_r < aett_pkg::MS_W'(aett_pkg::DEBOUNCE_MS)) ms_r <= ms_r + 1'b1;
          end
          aett_pkg::OP_SET_TURN: begin
            if (turn_r != tv_r) begin
              turn_r <= tv_r; dirty_r <= 1'b1; ms_r <= '0;
            end
          end
          aett_pkg::OP_SET_COUNTS: begin
            cur_r       <= sc_clamp;
            have_prev_r <= 1'b1;
          end
          aett_pkg::OP_CLEAR_DIRTY: dirty_r <= 1'b0;
          aett_pkg::OP_ZERO: begin
            if (turn_r) begin
              turn_r <= 1'b0; dirty_r <= 1'b1; ms_r <= '0;
            end
          end
          aett_pkg::OP_LOAD_TURN: begin
            turn_r <= tv_r; dirty_r <= 1'b0; ms_r <= '0;
          end
          default: ;
        endcase
      end

      if (cmd.apply) begin
        seen_r      <= 1'b1;
        have_prev_r <= 1'b1;
        cur_r       <= m;
        chk_r       <= 1'b1;
        if (have_prev_r && nt != turn_r) begin
          turn_r <= nt; dirty_r <= 1'b1; ms_r <= '0;
        end
      end

      if (cmd.div_start) begin
        rem_r <= '0;
        case (cmd.div_sel)
          aett_pkg::DIV_MOD: begin
            quo_r <= {pos_r, (aett_pkg::DVD_W-aett_pkg::POS_W)'(0)};
            cnt_r <= aett_pkg::CNT_W'(aett_pkg::POS_W);
            dvs_r <= cpr_r;
          end
          aett_pkg::DIV_ANG: begin
            quo_r <= {shaft_prod, (aett_pkg::DVD_W-aett_pkg::SHAFT_W)'(0)};
            cnt_r <= aett_pkg::CNT_W'(aett_pkg::SHAFT_W);
            dvs_r <= cpr_r;
          end
          default: begin
            quo_r <= prod_r;
            cnt_r <= aett_pkg::CNT_W'(aett_pkg::DVD_W);
            dvs_r <= den_eff;
          end
        endcase
      end else if (cmd.div_step) begin
        rem_r <= ge ? aett_pkg::CPR_W'(trial - {1'b0, dvs_r}) : trial[aett_pkg::CPR_W-1:0];
        quo_r <= {quo_r[aett_pkg::DVD_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
      end

      if (cmd.fin) begin
        turn_r  <= turn_f;
        dirty_r <= dirty_f;
        ms_r    <= ms_f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= aett_pkg::DVD_W'(quo_r[aett_pkg::SHAFT_W-1:0]) * aett_pkg::DVD_W'(num_eff);
    end
    if (cmd.fin) begin
      out_position_counts <= cur_r;
      out_extended_counts <= (cpr_r == '0) ? cur_r :
                             cur_r + (turn_f ? aett_pkg::POS_W'(cpr_r) : '0);
      out_angle_deg01     <= ang;
      out_angle_valid     <= avalid;
      out_turn            <= turn_f;
      out_persist_request <= dirty_f && (ms_f >= aett_pkg::MS_W'(aett_pkg::DEBOUNCE_MS));
    end
  end

endmodule

// ----- hw/rtl/absolute_encoder_turn_tracker_core.sv -----
// Absolute encoder turn tracker.
// Input channel in_ch carries one command item: a reading, a millisecond tick,
// set turn, set counts, clear dirty, zero or load turn. Every accepted item
// yields exactly one result item on out_ch with the position, the extended
// counts, the clamped angle in 0.01 degrees, the turn flag and the persist
// request, all as they stand after the command.
// Processing: a valid reading with nonzero counts per revolution runs a
// 24-step modulo, a 40-step angle divide and a 56-step scale divide, all
// on one shared radix-2 divider; other items run only the angle and
// scale divides; with counts per revolution zero, no divide runs. The
// block works on one item at a time and takes a new one in the cycle after
// the previous result has left the output register.
// Reset (rst_n low, synchronous) loads the register defaults (4096 counts,
// scale 1/1, axis 360 degrees) and clears position, turn and dirty state.
// If the receiver stalls, the result is held in the output register and the
// input stays not ready until it is taken.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// write only while the block is idle.
module absolute_encoder_turn_tracker_core (
  input  logic                           clk,
  input  logic                           rst_n,
  aett_in_if.sink                        in_ch,
  aett_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [aett_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aett_pkg::CFG_W-1:0]     cfg_data
);

`include "absolute_encoder_turn_tracker_core_defines.svh"

  aett_pkg::cmd_t  cmd;
  aett_pkg::stat_t stat;

  // sequence the item through the shared divider
  aett_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // hold config, tracker state, divider and result register
  aett_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_operation        (in_ch.operation),
    .in_position         (in_ch.position),
    .in_reading_valid    (in_ch.reading_valid),
    .in_turn_value       (in_ch.turn_value),
    .in_counts_value     (in_ch.counts_value),
    .cmd                 (cmd),
    .stat                (stat),
    .out_position_counts (out_ch.position_counts),
    .out_extended_counts (out_ch.extended_counts),
    .out_angle_deg01     (out_ch.angle_deg01),
    .out_angle_valid     (out_ch.angle_valid),
    .out_turn            (out_ch.turn),
    .out_persist_request (out_ch.persist_request)
  );

  `AETT_ASSERT(a_one_at_a_time, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "item accepted while busy")
  `AETT_ASSERT(a_no_accept_with_result, (in_ch.valid && in_ch.ready) |-> !out_ch.valid, "item accepted over a pending result")
  `AETT_ASSERT(a_angle_zero_invalid, (out_ch.valid && !out_ch.angle_valid) |-> (out_ch.angle_deg01 == '0), "angle nonzero without valid")

endmodule

// ----- tb/absolute_encoder_turn_tracker_core_tb.sv -----
module absolute_encoder_turn_tracker_core_tb;
  import aett_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One command item as offered on the input channel.
  typedef struct {
    op_t                    op;
    logic [POS_W-1:0]       pos;
    logic                   rv;
    logic                   tv;
    logic signed [CV_W-1:0] cv;
  } cmd_item_t;

  // One result item as the block reports it.
  typedef struct {
    logic [POS_W-1:0] pos_counts;
    logic [POS_W-1:0] ext_counts;
    logic [ANG_W-1:0] angle;
    logic             angle_ok;
    logic             turn;
    logic             persist;
  } track_res_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int LONG_HOLD      = 600;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  aett_in_if  in_if ();
  aett_out_if out_if ();

  absolute_encoder_turn_tracker_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the configuration registers, reset values.
  int unsigned m_cpr    = 4096;
  int unsigned m_invert = 0;
  int unsigned m_axmax  = 0;
  int unsigned m_num    = 1;
  int unsigned m_den    = 1;

  // Mirror of the tracker state.
  int unsigned t_pos      = 0;
  bit          t_have_prev = 0;
  bit          t_turn     = 0;
  bit          t_seen     = 0;
  bit          t_dirty    = 0;
  int unsigned t_ms       = 0;

  cmd_item_t  pending_cmds[$];
  track_res_t expected_res[$];
  cmd_item_t  cur_cmd;

  int n_pushed   = 0;
  int n_in       = 0;
  int n_out      = 0;
  int n_errors   = 0;
  int n_turn_set = 0;
  int n_persist  = 0;
  int idle_cnt   = 0;
  int hold_left  = 0;
  bit hold_done  = 0;
  int walk       = 0;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.operation = '0;
    in_if.position = '0;
    in_if.reading_valid = 1'b0;
    in_if.turn_value = 1'b0;
    in_if.counts_value = '0;
    out_if.ready = 1'b0;
  end

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Angle of a count in 0.01 degrees after the gear scale, kept 64 bits wide.
  function automatic longint unsigned scaled_angle(int unsigned c);
    longint unsigned shaft, num, den;
    if (m_cpr == 0) return 0;
    shaft = (longint'(c) * 36000) / m_cpr;
    num = (m_num != 0) ? m_num : 1;
    den = (m_den != 0) ? m_den : 1;
    return (shaft * num) / den;
  endfunction

  function automatic longint unsigned axis_limit();
    return (m_axmax != 0) ? m_axmax : FULL_TURN;
  endfunction

  // Change turn; a real change marks it dirty and restarts the ms count.
  function automatic void change_turn(bit t);
    if (t_turn != t) begin
      t_turn = t;
      t_dirty = 1;
      t_ms = 0;
    end
  endfunction

  function automatic void place_position(int unsigned p);
    longint signed d, half;
    bit nt;
    longint unsigned lim, overlap;
    if (m_cpr == 0) begin
      t_pos = p & 32'hFFFFFF;
      t_have_prev = 1;
      return;
    end
    if (t_have_prev) begin
      d = longint'(p) - longint'(t_pos);
      half = m_cpr / 2;
      nt = t_turn;
      if (d < -half) nt = 1;
      else if (d > half) nt = 0;
      change_turn(nt);
    end
    t_pos = p & 32'hFFFFFF;
    t_have_prev = 1;
    // Drop turn once the scaled angle leaves the overlap zone.
    if (t_turn) begin
      lim = axis_limit();
      overlap = (lim > FULL_TURN) ? lim - FULL_TURN : 0;
      if (scaled_angle(t_pos) > overlap) begin
        t_turn = 0;
        t_dirty = 1;
        t_ms = 0;
      end
    end
  endfunction

  function automatic track_res_t track_cmd(cmd_item_t c);
    track_res_t r;
    int unsigned m;
    longint signed sc;
    longint unsigned ext, ang, lim;
    bit ok;
    case (c.op)
      OP_READING: begin
        if (c.rv) begin
          t_seen = 1;
          m = c.pos;
          if (m_cpr != 0) begin
            m = c.pos % m_cpr;
            if (m_invert != 0) m = (m_cpr - m) % m_cpr;
          end
          place_position(m);
        end
      end
      OP_TICK: begin
        if (t_ms < DEBOUNCE_MS) t_ms++;
      end
      OP_SET_TURN: change_turn(c.tv);
      OP_SET_COUNTS: begin
        sc = c.cv;
        if (sc < 0) sc = 0;
        if (m_cpr != 0 && sc >= longint'(m_cpr)) sc = longint'(m_cpr) - 1;
        t_pos = int'(sc) & 32'hFFFFFF;
        t_have_prev = 1;
      end
      OP_CLEAR_DIRTY: t_dirty = 0;
      OP_ZERO: change_turn(0);
      OP_LOAD_TURN: begin
        t_turn = c.tv;
        t_dirty = 0;
        t_ms = 0;
      end
      default: ; // unused operation code: state stays as it is
    endcase

    if (m_cpr == 0) ext = t_pos;
    else ext = (t_turn ? longint'(m_cpr) : 0) + t_pos;

    ok = t_seen && (m_cpr != 0);
    ang = 0;
    if (ok) begin
      ang = scaled_angle(t_pos) + (t_turn ? FULL_TURN : 0);
      lim = axis_limit();
      if (ang > lim) ang = lim;
    end

    r.pos_counts = t_pos[POS_W-1:0];
    r.ext_counts = ext[POS_W-1:0];
    r.angle      = ang[ANG_W-1:0];
    r.angle_ok   = ok;
    r.turn       = t_turn;
    r.persist    = t_dirty && (t_ms >= DEBOUNCE_MS);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Idle pattern: sender 31 / receiver 59, then swapped, then none.
  // ---------------------------------------------------------------------
  function automatic int send_idle_pct();
    if (n_in < 520) return 31;
    if (n_in < 1040) return 59;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (n_in < 520) return 59;
    if (n_in < 1040) return 31;
    return 0;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: advance to the next pending item once the current one is taken.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_res.push_back(track_cmd(cur_cmd));
        n_in++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          cur_cmd = pending_cmds.pop_front();
          in_if.valid         <= 1'b1;
          in_if.operation     <= cur_cmd.op;
          in_if.position      <= cur_cmd.pos;
          in_if.reading_valid <= cur_cmd.rv;
          in_if.turn_value    <= cur_cmd.tv;
          in_if.counts_value  <= cur_cmd.cv;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each result item against the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    track_res_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_out++;
        if (expected_res.size() == 0) begin
          $error("result item with no expectation waiting");
          n_errors++;
        end else begin
          e = expected_res.pop_front();
          if (out_if.turn) n_turn_set++;
          if (out_if.persist_request) n_persist++;
          if (out_if.position_counts !== e.pos_counts) begin
            $error("position_counts exp %0d got %0d", e.pos_counts, out_if.position_counts);
            n_errors++;
          end
          if (out_if.extended_counts !== e.ext_counts) begin
            $error("extended_counts exp %0d got %0d", e.ext_counts, out_if.extended_counts);
            n_errors++;
          end
          if (out_if.angle_deg01 !== e.angle) begin
            $error("angle_deg01 exp %0d got %0d", e.angle, out_if.angle_deg01);
            n_errors++;
          end
          if (out_if.angle_valid !== e.angle_ok) begin
            $error("angle_valid exp %0d got %0d", e.angle_ok, out_if.angle_valid);
            n_errors++;
          end
          if (out_if.turn !== e.turn) begin
            $error("turn exp %0d got %0d", e.turn, out_if.turn);
            n_errors++;
          end
          if (out_if.persist_request !== e.persist) begin
            $error("persist_request exp %0d got %0d", e.persist, out_if.persist_request);
            n_errors++;
          end
        end
      end
      // Hold off once for a long stretch so the input backs up.
      if (!hold_done && n_out == 300) begin
        hold_done = 1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("absolute_encoder_turn_tracker_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic cfg_write(cfg_idx_t idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    case (idx)
      CFG_CPR:    m_cpr    = val & 16'hFFFF;
      CFG_INVERT: m_invert = val & 1;
      CFG_AXMAX:  m_axmax  = val & 17'h1FFFF;
      CFG_NUM:    m_num    = val & 16'hFFFF;
      CFG_DEN:    m_den    = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned cpr, int unsigned inv, int unsigned axmax,
                           int unsigned num, int unsigned den);
    cfg_write(CFG_CPR, cpr);
    cfg_write(CFG_INVERT, inv);
    cfg_write(CFG_AXMAX, axmax);
    cfg_write(CFG_NUM, num);
    cfg_write(CFG_DEN, den);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_cmd(op_t op, int unsigned pos, bit rv, bit tv, int cv);
    cmd_item_t c;
    c.op = op;
    c.pos = pos[POS_W-1:0];
    c.rv = rv;
    c.tv = tv;
    c.cv = cv[CV_W-1:0];
    pending_cmds.push_back(c);
    n_pushed++;
  endtask

  // Wait until every item is sent and every expected result is in, then let the
  // block settle for its latency.
  task automatic drain();
    while (!(pending_cmds.size() == 0 && n_in == n_pushed && expected_res.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly a walking shaft so wraps in both directions happen; ticks come
  // in bursts of 45 to 60, around the persist debounce. Count items, not
  // draws, so a tick burst uses up its share.
  task automatic push_random(int count);
    int first, span, step, sel;
    int unsigned p, rev;
    first = n_pushed;
    while (n_pushed - first < count) begin
      sel = $urandom_range(99);
      rev = (m_cpr != 0) ? m_cpr : 5000;
      if (sel < 55) begin
        span = rev * 3 / 5 + 1;
        step = int'($urandom_range(0, 2 * span)) - span;
        walk = walk + step;
        if (walk < 0) walk = walk + rev * 64;
        p = walk % rev;
        if ($urandom_range(9) == 0) p = $urandom;
        else p = p + rev * $urandom_range(0, 3);
        push_cmd(OP_READING, p, $urandom_range(9) != 0, $urandom_range(1), $urandom);
      end else if (sel < 60) begin
        repeat ($urandom_range(45, 60)) push_cmd(OP_TICK, $urandom, $urandom_range(1),
                                                 $urandom_range(1), $urandom);
      end else if (sel < 75) begin
        push_cmd(OP_TICK, $urandom, $urandom_range(1), $urandom_range(1), $urandom);
      end else begin
        push_cmd(op_t'($urandom_range(2, 7)), $urandom, $urandom_range(1),
                 $urandom_range(1), (sel < 85) ? int'($urandom_range(0, rev + 10)) : $urandom);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults, field extremes and every operation.
    push_cmd(OP_READING, 0, 1, 0, 0);
    push_cmd(OP_READING, 24'hFFFFFF, 1, 1, -1);
    push_cmd(OP_READING, 1234, 0, 0, 0);            // invalid frame is ignored
    push_cmd(OP_READING, 4000, 1, 0, 0);
    push_cmd(OP_READING, 100, 1, 0, 0);             // forward wrap
    push_cmd(OP_READING, 0, 1, 0, 0);
    push_cmd(OP_READING, 4095, 1, 0, 0);            // backward wrap
    push_cmd(OP_SET_TURN, 0, 0, 1, 0);
    push_cmd(OP_SET_TURN, 0, 0, 0, 0);
    push_cmd(OP_SET_COUNTS, 0, 0, 0, -16777216);
    push_cmd(OP_SET_COUNTS, 0, 0, 0, 16777215);
    push_cmd(OP_SET_COUNTS, 0, 0, 0, 5);
    push_cmd(OP_SET_TURN, 0, 0, 1, 0);
    push_cmd(OP_TICK, 0, 0, 0, 0);
    push_cmd(OP_CLEAR_DIRTY, 0, 0, 0, 0);
    push_cmd(OP_ZERO, 0, 0, 0, 0);
    push_cmd(OP_ZERO, 0, 0, 0, 0);                  // zero with turn already clear
    push_cmd(OP_LOAD_TURN, 0, 0, 1, 0);
    push_cmd(OP_LOAD_TURN, 0, 0, 0, 0);
    push_cmd(op_t'(3'd7), 24'hFFFFFF, 1, 1, -1);    // unused code, no effect
    push_random(200);
    drain();

    configure(4096, 0, 72000, 1, 1);
    push_random(220);
    drain();

    configure(65535, 1, 54000, 65535, 1);           // large scale, clamps hard
    push_random(220);
    drain();

    configure(0, 1, 72000, 7, 3);                   // pass-through positions
    push_random(200);
    drain();

    configure(1, 1, 0, 0, 0);
    push_random(180);
    drain();

    configure(360, 0, 40000, 3, 65535);
    push_random(220);
    drain();

    configure($urandom_range(2, 65535), $urandom_range(1), $urandom_range(0, 72000),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
    push_random(290);
    drain();

    $display("covered %0d items over 7 register settings, %0d results with turn set,",
             n_in, n_turn_set);
    $display("%0d with persist request, one long receiver stall", n_persist);
    if (n_errors == 0 && expected_res.size() == 0) begin
      $display("absolute_encoder_turn_tracker_core regression: pass");
    end else begin
      $display("absolute_encoder_turn_tracker_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/aett_pkg.sv
hw/rtl/aett_in_if.sv
hw/rtl/aett_out_if.sv
hw/rtl/aett_ctrl.sv
hw/rtl/aett_dp.sv
hw/rtl/absolute_encoder_turn_tracker_core.sv
tb/absolute_encoder_turn_tracker_core_tb.sv
